FILE: rtl/core/lsacp_pkg.sv
// Package: types, constants and helper functions of the LRU cache profiler.
package lsacp_pkg;

    localparam int WAYS      = 4;
    localparam int SET_COUNT = 64;
    localparam int SLOT_MAX  = 4;
    localparam int ADDR_W    = 32;
    localparam int SET_W     = 6;
    localparam int SET_LSB   = 6;
    localparam int TAG_LSB   = 12;
    localparam int TAG_W     = ADDR_W - TAG_LSB;
    localparam int CNT_W     = 32;
    localparam int FILL_W    = 3;
    localparam int WAY_W     = 2;
    localparam int ORDER_W   = SLOT_MAX * WAY_W;
    localparam int OUT_DATA_W = 128;

    localparam logic [ORDER_W-1:0] ORDER_RESET = 8'hE4;
    localparam logic [CNT_W-1:0]   CNT_MAX     = '1;

    localparam logic REQ_ACCESS = 1'b0;
    localparam logic REQ_DRAIN  = 1'b1;

    typedef struct packed {
        logic [WAYS-1:0][TAG_W-1:0] tags;
        logic [WAYS-1:0][CNT_W-1:0] hits;
        logic [FILL_W-1:0]          fill;
        logic [ORDER_W-1:0]         order;
        logic [CNT_W-1:0]           accesses;
        logic [CNT_W-1:0]           conflicts;
    } t_set_row;

    localparam int ROW_W = $bits(t_set_row);

    typedef struct packed {
        logic             hit;
        logic             evicted;
        logic [TAG_W-1:0] victim_tag;
        logic [CNT_W-1:0] victim_hits;
    } t_upd_status;

    typedef struct packed {
        logic             hit;
        logic             evicted;
        logic             line_valid;
        logic [SET_W-1:0] line_set;
        logic [TAG_W-1:0] line_tag;
        logic [CNT_W-1:0] line_hits;
        logic [CNT_W-1:0] set_accesses;
        logic [CNT_W-1:0] set_conflicts;
        logic             last;
    } t_out;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOKUP,
        S_DRAIN
    } t_state;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + CNT_W'(1);
    endfunction

    function automatic logic [WAY_W-1:0] slot_way(input logic [ORDER_W-1:0] order,
                                                  input logic [WAY_W-1:0] slot);
        return order[WAY_W*slot +: WAY_W];
    endfunction

    function automatic logic [ORDER_W-1:0] make_recent(input logic [ORDER_W-1:0] order,
                                                       input logic [WAY_W-1:0] way);
        logic [SLOT_MAX-1:0][WAY_W-1:0] slots;
        logic [WAY_W-1:0]               pos;
        logic                           found;
        slots = order;
        pos   = '0;
        found = 1'b0;
        for (int s = 0; s < WAYS; s++) begin
            if (!found && slots[s] == way) begin
                pos   = WAY_W'(s);
                found = 1'b1;
            end
        end
        for (int s = 0; s < WAYS - 1; s++) begin
            if (WAY_W'(s) >= pos) begin
                slots[s] = slots[s+1];
            end
        end
        slots[WAYS-1] = way;
        return slots;
    endfunction

endpackage

FILE: rtl/core/lsacp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module lsacp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/core/lsacp_set_update.sv
// Set update: tag match, LRU victim choice, counter and recency update of one set row.
module lsacp_set_update (
    input  lsacp_pkg::t_set_row             i_row,
    input  logic [lsacp_pkg::TAG_W-1:0]     i_tag,
    output lsacp_pkg::t_set_row             o_row,
    output lsacp_pkg::t_upd_status          o_status
);

    logic [lsacp_pkg::FILL_W-1:0] w_fill;
    logic                         w_hit;
    logic                         w_full;
    logic [lsacp_pkg::WAY_W-1:0]  w_match;
    logic [lsacp_pkg::WAY_W-1:0]  w_target;
    logic [lsacp_pkg::TAG_W-1:0]  w_vtag;
    logic [lsacp_pkg::CNT_W-1:0]  w_vhits;

    always_comb begin
        w_fill = (i_row.fill > lsacp_pkg::FILL_W'(lsacp_pkg::WAYS))
               ? lsacp_pkg::FILL_W'(lsacp_pkg::WAYS) : i_row.fill;
        w_full  = (w_fill >= lsacp_pkg::FILL_W'(lsacp_pkg::WAYS));
        w_hit   = 1'b0;
        w_match = '0;
        for (int w = 0; w < lsacp_pkg::WAYS; w++) begin
            if (!w_hit && lsacp_pkg::FILL_W'(w) < w_fill && i_row.tags[w] == i_tag) begin
                w_hit   = 1'b1;
                w_match = lsacp_pkg::WAY_W'(w);
            end
        end

        if (w_hit) begin
            w_target = w_match;
        end else if (w_full) begin
            w_target = lsacp_pkg::slot_way(i_row.order, '0);
        end else begin
            w_target = w_fill[lsacp_pkg::WAY_W-1:0];
        end

        o_row          = i_row;
        o_row.accesses = lsacp_pkg::sat_inc(i_row.accesses);
        o_row.order    = lsacp_pkg::make_recent(i_row.order, w_target);
        w_vtag         = '0;
        w_vhits        = '0;
        for (int w = 0; w < lsacp_pkg::WAYS; w++) begin
            if (lsacp_pkg::WAY_W'(w) == w_target) begin
                w_vtag  = i_row.tags[w];
                w_vhits = i_row.hits[w];
                if (w_hit) begin
                    o_row.hits[w] = lsacp_pkg::sat_inc(i_row.hits[w]);
                end else begin
                    o_row.tags[w] = i_tag;
                    o_row.hits[w] = '0;
                end
            end
        end
        if (!w_hit && w_full) begin
            o_row.conflicts = lsacp_pkg::sat_inc(i_row.conflicts);
        end else if (!w_hit) begin
            o_row.fill = w_fill + lsacp_pkg::FILL_W'(1);
        end

        o_status.hit         = w_hit;
        o_status.evicted     = !w_hit && w_full;
        o_status.victim_tag  = w_vtag;
        o_status.victim_hits = w_vhits;
    end

endmodule

FILE: rtl/core/lru_set_assoc_cache_profiler_core.sv
// Top level: LRU set-associative cache profiler with a per-set row memory.
// An access or empty-set drain reads its row into the RAM read register, then loads the
// output register once it is free. Other drains emit one result per valid line,
// scanning one slot per cycle while the output is free. A new request is taken only when
// idle; a result held by the sink stalls the input. Reset clears the per-set valid
// flags, so unwritten sets read as empty and requests are taken right after reset.
module lru_set_assoc_cache_profiler_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [lsacp_pkg::ADDR_W-1:0]        s_axis_tdata,  // address
    input  logic                                s_axis_tuser,  // req_type
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // line_set, line_tag, line_hits, set_accesses, set_conflicts, zero pad
    output logic [lsacp_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    output logic [2:0]                          m_axis_tuser,  // hit, evicted, line_valid
    output logic                                m_axis_tlast
);

    lsacp_pkg::t_state                 r_state, n_state;
    logic [lsacp_pkg::WAY_W-1:0]       r_slot, n_slot;
    logic                              r_out_valid, n_out_valid;
    lsacp_pkg::t_out                   r_out, n_out;
    logic [lsacp_pkg::SET_W-1:0]       r_set;
    logic [lsacp_pkg::TAG_W-1:0]       r_tag;
    logic                              r_req_drain;
    logic [lsacp_pkg::SET_COUNT-1:0]   r_set_init;

    logic                              w_accept;
    logic                              w_out_free;
    logic                              w_load;
    logic                              w_wr_en;
    logic [lsacp_pkg::ROW_W-1:0]       w_rd_data;
    lsacp_pkg::t_set_row               w_row;
    lsacp_pkg::t_set_row               w_new_row;
    lsacp_pkg::t_upd_status            w_status;
    logic [lsacp_pkg::SLOT_MAX-1:0]    w_mask;
    logic                              w_later;
    logic [lsacp_pkg::WAY_W-1:0]       w_dway;
    logic [lsacp_pkg::TAG_W-1:0]       w_dtag;
    logic [lsacp_pkg::CNT_W-1:0]       w_dhits;

    assign s_axis_tready = i_rst_n && (r_state == lsacp_pkg::S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;

    lsacp_ram #(
        .WIDTH (lsacp_pkg::ROW_W),
        .DEPTH (lsacp_pkg::SET_COUNT)
    ) u_row_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_set),
        .i_wr_data (w_new_row),
        .i_rd_en   (w_accept),
        .i_rd_addr (s_axis_tdata[lsacp_pkg::TAG_LSB-1:lsacp_pkg::SET_LSB]),
        .o_rd_data (w_rd_data)
    );

    always_comb begin
        w_row = w_rd_data;
        if (!r_set_init[r_set]) begin
            w_row.fill      = '0;
            w_row.order     = lsacp_pkg::ORDER_RESET;
            w_row.accesses  = '0;
            w_row.conflicts = '0;
        end
    end

    lsacp_set_update u_set_update (
        .i_row    (w_row),
        .i_tag    (r_tag),
        .o_row    (w_new_row),
        .o_status (w_status)
    );

    always_comb begin
        w_mask  = '0;
        w_later = 1'b0;
        for (int s = 0; s < lsacp_pkg::WAYS; s++) begin
            w_mask[s] = ({1'b0, lsacp_pkg::slot_way(w_row.order, lsacp_pkg::WAY_W'(s))}
                         < w_row.fill);
        end
        for (int s = 0; s < lsacp_pkg::SLOT_MAX; s++) begin
            if (lsacp_pkg::WAY_W'(s) > r_slot) begin
                w_later = w_later | w_mask[s];
            end
        end
        w_dway  = lsacp_pkg::slot_way(w_row.order, r_slot);
        w_dtag  = '0;
        w_dhits = '0;
        for (int w = 0; w < lsacp_pkg::WAYS; w++) begin
            if (lsacp_pkg::WAY_W'(w) == w_dway) begin
                w_dtag  = w_row.tags[w];
                w_dhits = w_row.hits[w];
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_slot  = r_slot;
        w_load  = 1'b0;
        w_wr_en = 1'b0;
        n_out   = r_out;
        unique case (r_state)
            lsacp_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = lsacp_pkg::S_LOOKUP;
                end
            end
            lsacp_pkg::S_LOOKUP: begin
                if (r_req_drain == lsacp_pkg::REQ_DRAIN) begin
                    if (w_mask != '0) begin
                        n_state = lsacp_pkg::S_DRAIN;
                        n_slot  = '0;
                    end else if (w_out_free) begin
                        w_load              = 1'b1;
                        n_out               = '0;
                        n_out.line_set      = r_set;
                        n_out.set_accesses  = w_row.accesses;
                        n_out.set_conflicts = w_row.conflicts;
                        n_out.last          = 1'b1;
                        n_state             = lsacp_pkg::S_IDLE;
                    end
                end else if (w_out_free) begin
                    w_wr_en             = 1'b1;
                    w_load              = 1'b1;
                    n_out.hit           = w_status.hit;
                    n_out.evicted       = w_status.evicted;
                    n_out.line_valid    = w_status.evicted;
                    n_out.line_set      = r_set;
                    n_out.line_tag      = w_status.evicted ? w_status.victim_tag : '0;
                    n_out.line_hits     = w_status.evicted ? w_status.victim_hits : '0;
                    n_out.set_accesses  = w_new_row.accesses;
                    n_out.set_conflicts = w_new_row.conflicts;
                    n_out.last          = 1'b1;
                    n_state             = lsacp_pkg::S_IDLE;
                end
            end
            lsacp_pkg::S_DRAIN: begin
                if (!w_mask[r_slot]) begin
                    n_slot = r_slot + lsacp_pkg::WAY_W'(1);
                end else if (w_out_free) begin
                    w_load              = 1'b1;
                    n_out.hit           = 1'b0;
                    n_out.evicted       = 1'b0;
                    n_out.line_valid    = 1'b1;
                    n_out.line_set      = r_set;
                    n_out.line_tag      = w_dtag;
                    n_out.line_hits     = w_dhits;
                    n_out.set_accesses  = w_row.accesses;
                    n_out.set_conflicts = w_row.conflicts;
                    n_out.last          = !w_later;
                    if (w_later) begin
                        n_slot = r_slot + lsacp_pkg::WAY_W'(1);
                    end else begin
                        n_state = lsacp_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = lsacp_pkg::S_IDLE;
            end
        endcase
        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lsacp_pkg::S_IDLE;
            r_slot      <= '0;
            r_out_valid <= 1'b0;
            r_set_init  <= '0;
        end else begin
            r_state     <= n_state;
            r_slot      <= n_slot;
            r_out_valid <= n_out_valid;
            if (w_wr_en) begin
                r_set_init[r_set] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_set       <= s_axis_tdata[lsacp_pkg::TAG_LSB-1:lsacp_pkg::SET_LSB];
            r_tag       <= s_axis_tdata[lsacp_pkg::ADDR_W-1:lsacp_pkg::TAG_LSB];
            r_req_drain <= s_axis_tuser;
        end
        r_out <= n_out;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = {r_out.line_valid, r_out.evicted, r_out.hit};
    assign m_axis_tlast  = r_out.last;
    assign m_axis_tdata  = {6'd0, r_out.set_conflicts, r_out.set_accesses, r_out.line_hits,
                            r_out.line_tag, r_out.line_set};

    a_accept_to_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state == lsacp_pkg::S_LOOKUP)
        else $error("accepted request did not enter lookup");

    a_drain_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_req_drain == lsacp_pkg::REQ_DRAIN || r_state != lsacp_pkg::S_LOOKUP) |-> !w_wr_en)
        else $error("row written outside an access lookup");

    a_access_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |=> r_out_valid && m_axis_tlast && r_state == lsacp_pkg::S_IDLE)
        else $error("access write-back without a final result");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |-> w_new_row.fill <= lsacp_pkg::FILL_W'(lsacp_pkg::WAYS))
        else $error("fill count beyond way count");

endmodule

FILE: sim/tb.sv
// Self-checking bench for the LRU cache profiler: access and drain traffic against a predictor.
module tb;
    import lsacp_pkg::*;

    class lru_profile_predictor;
        logic [TAG_W-1:0]  line_tags  [SET_COUNT][SLOT_MAX];
        logic [CNT_W-1:0]  line_hits  [SET_COUNT][SLOT_MAX];
        logic [FILL_W-1:0] filled     [SET_COUNT];
        logic [WAY_W-1:0]  recency    [SET_COUNT][SLOT_MAX];
        logic [CNT_W-1:0]  accesses   [SET_COUNT];
        logic [CNT_W-1:0]  conflicts  [SET_COUNT];
        t_out              expected_reports[$];
        int                report_mismatches;

        function new();
            report_mismatches = 0;
            for (int s = 0; s < SET_COUNT; s++) begin
                filled[s]    = '0;
                accesses[s]  = '0;
                conflicts[s] = '0;
                for (int k = 0; k < SLOT_MAX; k++) begin
                    recency[s][k]   = WAY_W'(k);
                    line_tags[s][k] = '0;
                    line_hits[s][k] = '0;
                end
            end
        endfunction

        function logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
            return (v == CNT_MAX) ? v : v + 1'b1;
        endfunction

        // move a way to the most recent slot, sliding newer slots down
        function void promote(input int set, input logic [WAY_W-1:0] way);
            int pos;
            pos = 0;
            for (int k = WAYS - 1; k >= 0; k--) begin
                if (recency[set][k] == way) pos = k;
            end
            for (int k = pos; k < WAYS - 1; k++) begin
                recency[set][k] = recency[set][k+1];
            end
            recency[set][WAYS-1] = way;
        endfunction

        function t_out report(input int set, input logic h, input logic ev, input logic lv,
                              input logic [TAG_W-1:0] tag, input logic [CNT_W-1:0] hits);
            t_out r;
            r.hit           = h;
            r.evicted       = ev;
            r.line_valid    = lv;
            r.line_set      = SET_W'(set);
            r.line_tag      = tag;
            r.line_hits     = hits;
            r.set_accesses  = accesses[set];
            r.set_conflicts = conflicts[set];
            r.last          = 1'b1;
            return r;
        endfunction

        function void note_request(input logic req, input logic [ADDR_W-1:0] addr);
            int               set;
            int               fill;
            int               way;
            logic [TAG_W-1:0] tag;
            t_out             lines[$];
            t_out             r;
            set  = int'(addr[SET_LSB +: SET_W]);
            tag  = addr[TAG_LSB +: TAG_W];
            fill = (filled[set] > FILL_W'(WAYS)) ? WAYS : int'(filled[set]);
            if (req == REQ_DRAIN) begin
                for (int k = 0; k < WAYS; k++) begin
                    way = int'(recency[set][k]);
                    if (way < fill) begin
                        r = report(set, 1'b0, 1'b0, 1'b1, line_tags[set][way],
                                   line_hits[set][way]);
                        r.last = 1'b0;
                        lines.insert(lines.size(), r);
                    end
                end
                if (lines.size() == 0) begin
                    lines.insert(0, report(set, 1'b0, 1'b0, 1'b0, '0, '0));
                end
                lines[lines.size()-1].last = 1'b1;
                foreach (lines[i]) expected_reports.insert(expected_reports.size(), lines[i]);
                return;
            end
            accesses[set] = bump(accesses[set]);
            for (int w = 0; w < fill; w++) begin
                if (line_tags[set][w] == tag) begin
                    line_hits[set][w] = bump(line_hits[set][w]);
                    promote(set, WAY_W'(w));
                    expected_reports.insert(expected_reports.size(),
                                            report(set, 1'b1, 1'b0, 1'b0, '0, '0));
                    return;
                end
            end
            if (fill >= WAYS) begin
                way = int'(recency[set][0]);
                conflicts[set] = bump(conflicts[set]);
                r = report(set, 1'b0, 1'b1, 1'b1, line_tags[set][way], line_hits[set][way]);
                line_tags[set][way] = tag;
                line_hits[set][way] = '0;
                promote(set, WAY_W'(way));
                expected_reports.insert(expected_reports.size(), r);
                return;
            end
            line_tags[set][fill] = tag;
            line_hits[set][fill] = '0;
            filled[set] = FILL_W'(fill + 1);
            promote(set, WAY_W'(fill));
            expected_reports.insert(expected_reports.size(),
                                    report(set, 1'b0, 1'b0, 1'b0, '0, '0));
        endfunction

        function string describe(input t_out r);
            return $sformatf({"hit=%0b ev=%0b lv=%0b set=%0d tag=%h hits=%0d ",
                              "acc=%0d conf=%0d last=%0b"},
                             r.hit, r.evicted, r.line_valid, r.line_set, r.line_tag,
                             r.line_hits, r.set_accesses, r.set_conflicts, r.last);
        endfunction

        function void check_report(input t_out got);
            t_out want;
            if (expected_reports.size() == 0) begin
                report_mismatches++;
                if (report_mismatches <= 10) $display("unexpected result: %s", describe(got));
                return;
            end
            want = expected_reports.pop_front();
            if (got !== want) begin
                report_mismatches++;
                if (report_mismatches <= 10) begin
                    $display("mismatch: expected %s", describe(want));
                    $display("          actual   %s", describe(got));
                end
            end
        endfunction

        function int pending();
            return expected_reports.size();
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [ADDR_W-1:0]     s_axis_tdata = '0;   // address
    logic                  s_axis_tuser = 1'b0; // req_type
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // line_set, line_tag, line_hits, set_accesses, set_conflicts, zero pad
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [2:0]            m_axis_tuser;        // hit, evicted, line_valid
    logic                  m_axis_tlast;

    lru_profile_predictor board;
    int                   sender_gap_pct = 24;
    int                   sink_stall_pct = 63;
    logic                 hold_armed = 1'b0;
    logic [SET_W-1:0]     hot_sets[4];
    logic [TAG_W-1:0]     hot_tags[6];

    lru_set_assoc_cache_profiler_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic logic [ADDR_W-1:0] line_addr(input logic [TAG_W-1:0] tag,
                                                    input logic [SET_W-1:0] set,
                                                    input logic [5:0] offset);
        return {tag, set, offset};
    endfunction

    task automatic offer(input logic req, input logic [ADDR_W-1:0] addr);
        if ($urandom_range(99) < sender_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < sender_gap_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= addr;
        s_axis_tuser  <= req;
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_request(req, addr);
    endtask

    task automatic random_traffic(input int count);
        int               pick;
        logic [ADDR_W-1:0] addr;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 12) begin
                addr = $urandom();
                addr[SET_LSB +: SET_W] = hot_sets[$urandom_range(3)];
                offer(REQ_DRAIN, addr);
            end else if (pick < 22) begin
                offer(1'($urandom_range(1)), $urandom());
            end else begin
                offer(REQ_ACCESS, line_addr(hot_tags[$urandom_range(5)],
                                            hot_sets[$urandom_range(3)],
                                            6'($urandom_range(63))));
            end
        end
    endtask

    // result sink: check, then choose ready for the next cycle
    initial begin
        t_out got;
        int   hold_left;
        logic hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) begin
                got.hit           = m_axis_tuser[0];
                got.evicted       = m_axis_tuser[1];
                got.line_valid    = m_axis_tuser[2];
                got.line_set      = m_axis_tdata[5:0];
                got.line_tag      = m_axis_tdata[25:6];
                got.line_hits     = m_axis_tdata[57:26];
                got.set_accesses  = m_axis_tdata[89:58];
                got.set_conflicts = m_axis_tdata[121:90];
                got.last          = m_axis_tlast;
                board.check_report(got);
            end
            if (hold_armed && !hold_done) begin
                hold_done = 1'b1;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    initial begin
        board = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        offer(REQ_DRAIN, line_addr(20'h0, 6'd0, 6'd0));
        offer(REQ_ACCESS, 32'h0000_0000);
        offer(REQ_ACCESS, 32'hFFFF_FFFF);
        offer(REQ_ACCESS, line_addr(20'h1, 6'd0, 6'h3F));
        offer(REQ_ACCESS, line_addr(20'h2, 6'd0, 6'h15));
        offer(REQ_ACCESS, line_addr(20'h3, 6'd0, 6'h2A));
        offer(REQ_ACCESS, line_addr(20'h0, 6'd0, 6'h3F));
        offer(REQ_ACCESS, line_addr(20'h0, 6'd0, 6'h01));
        offer(REQ_ACCESS, line_addr(20'h2, 6'd0, 6'h00));
        offer(REQ_DRAIN, line_addr(20'hFFFFF, 6'd0, 6'h3F));
        offer(REQ_ACCESS, line_addr(20'h4, 6'd0, 6'h00));
        offer(REQ_ACCESS, line_addr(20'h5, 6'd0, 6'h00));
        offer(REQ_DRAIN, line_addr(20'h0, 6'd0, 6'h00));
        offer(REQ_DRAIN, 32'hFFFF_FFFF);
        offer(REQ_ACCESS, line_addr(20'hFFFFF, 6'd63, 6'h00));
        offer(REQ_ACCESS, line_addr(20'hAAAAA, 6'd42, 6'h15));
        offer(REQ_ACCESS, line_addr(20'h55555, 6'd21, 6'h2A));
        offer(REQ_DRAIN, line_addr(20'h0, 6'd63, 6'h00));

        foreach (hot_sets[i]) hot_sets[i] = 6'($urandom_range(63));
        foreach (hot_tags[i]) hot_tags[i] = 20'($urandom());
        random_traffic(80);

        sender_gap_pct <= 63;
        sink_stall_pct <= 24;
        hold_armed     <= 1'b1;
        random_traffic(80);

        sender_gap_pct <= 0;
        sink_stall_pct <= 0;
        random_traffic(80);
        s_axis_tvalid <= 1'b0;

        while (board.pending() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (board.report_mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

FILE: filelist.f
rtl/core/lsacp_pkg.sv
rtl/core/lsacp_ram.sv
rtl/core/lsacp_set_update.sv
rtl/core/lru_set_assoc_cache_profiler_core.sv
sim/tb.sv
